>>> rtl/core/tewt_pkg.sv
`timescale 1ns / 1ps
// Package for the tensor element widen and transpose block: format codes,
// register indexes, element kinds and the queue entry. No dependencies.
package tewt_pkg;

    localparam int MAX_DIM_DEFAULT     = 65536;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int CFG_DATA_W          = 17;
    localparam int CFG_INDEX_W         = 2;
    localparam int WORD_W              = 32;
    localparam int FP32_BIAS_ADJ       = 127 - 15;

    typedef enum logic [1:0] {
        FMT_F32  = 2'd0,
        FMT_F16  = 2'd1,
        FMT_BF16 = 2'd2,
        FMT_I32  = 2'd3
    } fmt_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FORMAT    = 2'd0,
        REG_TRANSPOSE = 2'd1,
        REG_ROWS      = 2'd2,
        REG_COLS      = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_PASS      = 3'd0,
        KIND_BF16      = 3'd1,
        KIND_HALF_ZERO = 3'd2,
        KIND_HALF_SUB  = 3'd3,
        KIND_HALF_NORM = 3'd4,
        KIND_HALF_SPEC = 3'd5
    } kind_t;

    typedef struct packed {
        logic [WORD_W-1:0] raw;
        logic [WORD_W-1:0] dest;
        logic              last;
        kind_t             kind;
    } entry_t;

endpackage

>>> rtl/core/tewt_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, source position counters, destination
// index and element classification. Depends on tewt_pkg.
module tewt_front #(
    parameter int MAX_DIM = tewt_pkg::MAX_DIM_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tewt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tewt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tewt_pkg::WORD_W-1:0]       s_tdata,
    input  logic                              push_ready,
    output logic                              push_valid,
    output tewt_pkg::entry_t                  push_entry
);
    import tewt_pkg::*;

    localparam int POS_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int EXT_W = CFG_DATA_W - POS_W;

    fmt_t                  format_reg;
    logic                  transpose_reg;
    logic [CFG_DATA_W-1:0] rows_cfg_reg;
    logic [CFG_DATA_W-1:0] cols_cfg_reg;
    logic [POS_W-1:0]      row_pos_reg, row_pos_next;
    logic [POS_W-1:0]      col_pos_reg, col_pos_next;
    logic [WORD_W-1:0]     dest_reg, dest_next;

    logic [CFG_DATA_W-1:0] rows, cols;
    logic [POS_W-1:0]      row_cur, col_cur;
    logic [WORD_W-1:0]     dest_cur;
    logic [CFG_DATA_W-1:0] row_inc, col_inc;
    logic                  out_of_range, last_row, last_col, transposed, accept;
    logic [4:0]            half_exp;
    logic [9:0]            half_mant;

    function automatic logic [CFG_DATA_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W-1:0] r;
        if (v == '0) begin
            r = CFG_DATA_W'(1);
        end else if (v > CFG_DATA_W'(MAX_DIM)) begin
            r = CFG_DATA_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign rows       = clamp_dim(rows_cfg_reg);
    assign cols       = clamp_dim(cols_cfg_reg);
    assign transposed = transpose_reg && (format_reg != FMT_I32);
    assign accept     = s_tvalid && push_ready;
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    assign out_of_range = ({{EXT_W{1'b0}}, row_pos_reg} >= rows)
                       || ({{EXT_W{1'b0}}, col_pos_reg} >= cols);
    assign row_cur  = out_of_range ? '0 : row_pos_reg;
    assign col_cur  = out_of_range ? '0 : col_pos_reg;
    assign dest_cur = out_of_range ? '0 : dest_reg;
    assign row_inc  = {{EXT_W{1'b0}}, row_cur} + CFG_DATA_W'(1);
    assign col_inc  = {{EXT_W{1'b0}}, col_cur} + CFG_DATA_W'(1);
    assign last_row = (row_inc == rows);
    assign last_col = (col_inc == cols);

    always_comb begin
        row_pos_next = row_cur;
        col_pos_next = col_cur;
        dest_next    = dest_cur;
        if (!last_col) begin
            col_pos_next = col_inc[POS_W-1:0];
            dest_next    = dest_cur + (transposed ? {{(WORD_W-CFG_DATA_W){1'b0}}, rows}
                                                  : WORD_W'(1));
        end else begin
            col_pos_next = '0;
            if (!last_row) begin
                row_pos_next = row_inc[POS_W-1:0];
                dest_next    = transposed ? {{(WORD_W-CFG_DATA_W){1'b0}}, row_inc}
                                          : dest_cur + WORD_W'(1);
            end else begin
                row_pos_next = '0;
                dest_next    = '0;
            end
        end
    end

    assign half_exp  = s_tdata[14:10];
    assign half_mant = s_tdata[9:0];

    always_comb begin
        push_entry.raw  = s_tdata;
        push_entry.dest = dest_cur;
        push_entry.last = last_row && last_col;
        unique case (format_reg) inside
            FMT_F16: begin
                if (half_exp == 5'd0) begin
                    push_entry.kind = (half_mant == 10'd0) ? KIND_HALF_ZERO : KIND_HALF_SUB;
                end else if (half_exp == 5'h1F) begin
                    push_entry.kind = KIND_HALF_SPEC;
                end else begin
                    push_entry.kind = KIND_HALF_NORM;
                end
            end
            FMT_BF16:         push_entry.kind = KIND_BF16;
            FMT_F32, FMT_I32: push_entry.kind = KIND_PASS;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg    <= FMT_F32;
            transpose_reg <= 1'b0;
            rows_cfg_reg  <= CFG_DATA_W'(1);
            cols_cfg_reg  <= CFG_DATA_W'(1);
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            dest_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_FORMAT:    format_reg    <= fmt_t'(cfg_data[1:0]);
                REG_TRANSPOSE: transpose_reg <= cfg_data[0];
                REG_ROWS:      rows_cfg_reg  <= cfg_data;
                REG_COLS:      cols_cfg_reg  <= cfg_data;
            endcase
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            dest_reg    <= '0;
        end else if (accept) begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            dest_reg    <= dest_next;
        end
    end

endmodule

>>> rtl/core/tewt_queue.sv
`timescale 1ns / 1ps
// Short queue of classified elements between the front and back ends.
// Depends on tewt_pkg.
module tewt_queue #(
    parameter int DEPTH = tewt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  tewt_pkg::entry_t push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output tewt_pkg::entry_t pop_entry
);
    import tewt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/tewt_back.sv
`timescale 1ns / 1ps
// Back end: widens F16/BF16 elements to FP32, passes F32/I32 unchanged
// and holds the result beat in the output register. Depends on tewt_pkg.
module tewt_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  tewt_pkg::entry_t               pop_entry,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [2*tewt_pkg::WORD_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import tewt_pkg::*;

    logic                valid_reg;
    logic [WORD_W-1:0]   value_reg, value_next;
    logic [WORD_W-1:0]   dest_reg;
    logic                last_reg;
    logic                sign;
    logic [7:0]          exp_adj;

    assign pop_ready = !valid_reg || m_tready;
    assign sign      = pop_entry.raw[15];
    assign exp_adj   = {3'b000, pop_entry.raw[14:10]} + 8'(FP32_BIAS_ADJ);

    always_comb begin
        case (pop_entry.kind)
            KIND_BF16:      value_next = {pop_entry.raw[15:0], 16'h0000};
            KIND_HALF_ZERO: value_next = {sign, 31'd0};
            KIND_HALF_SUB:  value_next = '0;
            KIND_HALF_NORM: value_next = {sign, exp_adj, pop_entry.raw[9:0], 13'd0};
            KIND_HALF_SPEC: value_next = {sign, 8'hFF, pop_entry.raw[9:0], 13'd0};
            default:        value_next = pop_entry.raw;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop_ready) begin
            valid_reg <= pop_valid;
        end
        if (pop_valid && pop_ready) begin
            value_reg <= value_next;
            dest_reg  <= pop_entry.dest;
            last_reg  <= pop_entry.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {dest_reg, value_reg};
    assign m_tlast  = last_reg;

endmodule

>>> rtl/core/tensor_element_widen_transpose_top.sv
`timescale 1ns / 1ps
// Top level of the tensor element widen and transpose block.
// Depends on tewt_pkg, tewt_front, tewt_queue and tewt_back.
//
//   Port group   Direction  Beat contents (lowest bit first)
//   s_*          in         tdata: raw_word[31:0]
//   m_*          out        tdata: value_bits[31:0], dest_index[63:32]; tlast: last_flag
//   cfg_*        in         cfg_index selects the register, cfg_data carries its value
//
// One beat is taken per cycle while s_tready is high; a taken beat is written
// into the queue, then popped into the output register that drives m_*.
// Reset and any register write restart the tensor at row 0, column 0.
// The queue holds up to QUEUE_DEPTH beats while m_tready is low; s_tready
// falls only when it is full.
module tensor_element_widen_transpose_top #(
    parameter int MAX_DIM     = tewt_pkg::MAX_DIM_DEFAULT,
    parameter int QUEUE_DEPTH = tewt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tewt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tewt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tewt_pkg::WORD_W-1:0]      s_tdata,   // raw_word
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [2*tewt_pkg::WORD_W-1:0]    m_tdata,   // value_bits, dest_index
    output logic                             m_tlast
);
    import tewt_pkg::*;

    logic   push_valid, push_ready, pop_valid, pop_ready;
    entry_t push_entry, pop_entry;

    tewt_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    tewt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    tewt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
